FILE: rtl/core/mws_pkg.sv
package mws_pkg;

  // field widths of the stream and configuration ports
  localparam int SAMPLE_W    = 15;
  localparam int IN_TDATA_W  = 16;
  localparam int SUM_W       = 19;
  localparam int ROW_W       = 10;
  localparam int COL_W       = 9;
  localparam int OUT_TDATA_W = 40;
  localparam int HEIGHT_W    = 11;
  localparam int WIDTH_W     = 10;
  localparam int CFG_DATA_W  = 11;

  // frame limits
  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 1024;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_HEIGHT = 1'b0,
    REG_WIDTH  = 1'b1
  } cfg_reg_t;

  typedef logic [ROW_W-1:0] row_t;

  // per-sample classification made by the front end
  typedef struct packed {
    logic win;    // a full 3x3 window ends at this sample
    logic first;  // first window of the frame
    logic last;   // last sample of the frame
    row_t row;    // top row of the window ending here
  } win_ctrl_t;

endpackage

FILE: rtl/core/max_window_sum_3x3.sv
// Maximum 3x3 window sum over a streamed frame. Samples enter in row-major
// order, one per cycle with no gaps required; frame height and width come
// from the configuration port, and any configuration write restarts the
// frame. After the last sample of a frame one transaction carries the
// largest window sum and the top row and left column of the first window
// that reached it. A sample is taken every cycle as long as the four-entry
// queue between the position tracker and the sum pipeline has room; the
// sum pipeline runs one sample per cycle, set by its single line store RAM
// (MAX_WIDTH words, one read and one write port, no clearing pass needed),
// unless a finished frame waits on a full output; the result is registered after the window sum.
module max_window_sum_3x3
  import mws_pkg::*;
#(
  parameter int MAX_WIDTH   = 512,
  parameter int SAMPLE_BITS = 15
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wen,
  input  logic [0:0]             cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // sample[14:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // best_sum[18:0], best_row[28:19], best_col[37:29]
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int CTW = $bits(win_ctrl_t);
  localparam int DW = CTW + CW + SAMPLE_BITS;

  logic                   push;
  logic                   q_full;
  logic                   q_valid;
  logic                   q_pop;
  win_ctrl_t              f_ctrl;
  logic [CW-1:0]          f_col;
  logic [SAMPLE_BITS-1:0] f_sample;
  logic [DW-1:0]          q_wdata;
  logic [DW-1:0]          q_rdata;
  win_ctrl_t              q_ctrl;
  logic [CW-1:0]          q_col;
  logic [SAMPLE_BITS-1:0] q_sample;

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;
  assign f_sample  = SAMPLE_BITS'(in_tdata[SAMPLE_W-1:0]);
  assign q_wdata   = {f_ctrl, f_col, f_sample};

  assign q_ctrl   = q_rdata[DW-1 -: CTW];
  assign q_col    = q_rdata[SAMPLE_BITS +: CW];
  assign q_sample = q_rdata[SAMPLE_BITS-1:0];

  // position tracking and classification
  mws_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .push     (push),
    .ctrl     (f_ctrl),
    .col      (f_col)
  );

  // decoupling queue
  mws_queue #(
    .DW(DW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // line store, window sums and best tracking
  mws_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ctrl    (q_ctrl),
    .q_col     (q_col),
    .q_sample  (q_sample),
    .pop       (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

FILE: rtl/core/mws_front.sv
module mws_front
  import mws_pkg::*;
#(
  parameter int MAX_WIDTH = 512,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [0:0]            cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  push,
  output win_ctrl_t             ctrl,
  output logic [CW-1:0]         col
);

  logic [ROW_W-1:0] h_last_r, h_last_nxt;
  logic [CW-1:0]    w_last_r, w_last_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [HEIGHT_W-1:0] hv;
  logic [31:0]         wv;

  assign hv = cfg_wdata[HEIGHT_W-1:0];
  assign wv = 32'(cfg_wdata[WIDTH_W-1:0]);

  // classify the sample at the current position
  always_comb begin
    ctrl.win   = (row_r >= ROW_W'(2)) && (col_r >= CW'(2));
    ctrl.first = (row_r == ROW_W'(2)) && (col_r == CW'(2));
    ctrl.last  = (row_r == h_last_r) && (col_r == w_last_r);
    ctrl.row   = row_r - ROW_W'(2);
    col        = col_r;
  end

  // frame size registers and position counters
  always_comb begin
    h_last_nxt = h_last_r;
    w_last_nxt = w_last_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    priority if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_HEIGHT: begin
          priority if (hv < HEIGHT_W'(MIN_DIM)) begin
            h_last_nxt = ROW_W'(MIN_DIM - 1);
          end else if (hv > HEIGHT_W'(MAX_HEIGHT)) begin
            h_last_nxt = ROW_W'(MAX_HEIGHT - 1);
          end else begin
            h_last_nxt = ROW_W'(hv - HEIGHT_W'(1));
          end
        end
        REG_WIDTH: begin
          priority if (wv < 32'(MIN_DIM)) begin
            w_last_nxt = CW'(MIN_DIM - 1);
          end else if (wv > 32'(MAX_WIDTH)) begin
            w_last_nxt = CW'(MAX_WIDTH - 1);
          end else begin
            w_last_nxt = CW'(wv - 32'd1);
          end
        end
      endcase
      row_nxt = '0;
      col_nxt = '0;
    end else if (push) begin
      priority if (ctrl.last) begin
        row_nxt = '0;
        col_nxt = '0;
      end else if (col_r == w_last_r) begin
        row_nxt = row_r + ROW_W'(1);
        col_nxt = '0;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_last_r <= ROW_W'(MIN_DIM - 1);
      w_last_r <= CW'(MIN_DIM - 1);
      row_r    <= '0;
      col_r    <= '0;
    end else begin
      h_last_r <= h_last_nxt;
      w_last_r <= w_last_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
    end
  end

`ifndef SYNTHESIS
  // the last sample of a frame rewinds the position
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    push && ctrl.last |=> row_r == '0 && col_r == '0)
    else $error("position not rewound after last sample");
`endif

endmodule

FILE: rtl/core/mws_queue.sv
module mws_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output logic [DW-1:0] rdata
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign valid = (cnt_r != '0);
  assign rdata = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + AW'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (AW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (AW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a lone push grows the fill count by one
  a_fill_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == (AW+1)'($past(cnt_r) + (AW+1)'(1)))
    else $error("queue count did not follow push");
`endif

endmodule

FILE: rtl/core/mws_back.sv
module mws_back
  import mws_pkg::*;
#(
  parameter int MAX_WIDTH   = 512,
  parameter int SAMPLE_BITS = 15,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  win_ctrl_t              q_ctrl,
  input  logic [CW-1:0]          q_col,
  input  logic [SAMPLE_BITS-1:0] q_sample,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int SB  = SAMPLE_BITS;
  localparam int CSW = SB + 2;
  localparam int WSW = SB + 4;

  // line store: each word holds {row r-2, row r-1} of one column
  logic [2*SB-1:0] ls_mem [MAX_WIDTH];
  logic [2*SB-1:0] rd_r;

  // stage 1: line store read
  logic            s1_v_r;
  win_ctrl_t       s1_ctrl_r;
  logic [CW-1:0]   s1_col_r;
  logic [SB-1:0]   s1_sample_r;
  // stage 2: last three column sums
  logic            s2_v_r;
  win_ctrl_t       s2_ctrl_r;
  logic [CW-1:0]   s2_col_r;
  logic [CSW-1:0]  cs0_r, cs1_r, cs2_r;
  // stage 3: window sum
  logic            s3_v_r;
  win_ctrl_t       s3_ctrl_r;
  logic [CW-1:0]   s3_col_r;
  logic [WSW-1:0]  s3_sum_r;
  // best window so far
  logic [WSW-1:0]  best_sum_r;
  row_t            best_row_r;
  logic [CW-1:0]   best_col_r;
  // output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic           blk3, en3, load2, load1, take;
  logic [CSW-1:0] colsum;
  logic [WSW-1:0] win_sum;
  logic [WSW-1:0] bsum;
  row_t           brow;
  logic [CW-1:0]  bcol;

  // stall chain: only a finished frame waiting on a full output blocks
  assign blk3  = s3_v_r && s3_ctrl_r.last && out_valid_r && !out_tready;
  assign en3   = !blk3;
  assign load2 = en3 || !s2_v_r;
  assign load1 = load2 || !s1_v_r;
  assign pop   = q_valid && load1;

  // column and window sums
  assign colsum  = CSW'(rd_r[2*SB-1:SB]) + CSW'(rd_r[SB-1:0]) + CSW'(s1_sample_r);
  assign win_sum = WSW'(cs0_r) + WSW'(cs1_r) + WSW'(cs2_r);

  // best window update, first window always taken, ties keep the older one
  always_comb begin
    take = s3_ctrl_r.win && (s3_ctrl_r.first || (s3_sum_r > best_sum_r));
    bsum = take ? s3_sum_r : best_sum_r;
    brow = take ? s3_ctrl_r.row : best_row_r;
    bcol = take ? (s3_col_r - CW'(2)) : best_col_r;
  end

  // line store read and write-back
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_r <= ls_mem[q_col];
    end
    if (load2 && s1_v_r) begin
      ls_mem[s1_col_r] <= {rd_r[SB-1:0], s1_sample_r};
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_ctrl_r   <= q_ctrl;
      s1_col_r    <= q_col;
      s1_sample_r <= q_sample;
    end
    if (load2 && s1_v_r) begin
      s2_ctrl_r <= s1_ctrl_r;
      s2_col_r  <= s1_col_r;
      cs0_r     <= cs1_r;
      cs1_r     <= cs2_r;
      cs2_r     <= colsum;
    end
    if (en3 && s2_v_r) begin
      s3_ctrl_r <= s2_ctrl_r;
      s3_col_r  <= s2_col_r;
      s3_sum_r  <= win_sum;
    end
    if (en3 && s3_v_r) begin
      best_sum_r <= bsum;
      best_row_r <= brow;
      best_col_r <= bcol;
      if (s3_ctrl_r.last) begin
        out_data_r <= {2'b00, COL_W'(bcol), brow, SUM_W'(bsum)};
      end
    end
  end

  // pipeline valids and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load1) begin
        s1_v_r <= q_valid;
      end
      if (load2) begin
        s2_v_r <= s1_v_r;
      end
      if (en3) begin
        s3_v_r <= s2_v_r;
      end
      priority if (en3 && s3_v_r && s3_ctrl_r.last) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // every frame ends on a full window
  a_last_is_window: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && s3_ctrl_r.last |-> s3_ctrl_r.win)
    else $error("frame end without a full window");

  // a finished frame always shows up at the output
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && s3_ctrl_r.last && en3 |=> out_valid_r)
    else $error("frame result lost");
`endif

endmodule
